### rtl/spc_pkg.sv
// shared types and constants for the stream pattern censor
package spc_pkg;

    localparam int BYTE_W = 8;
    localparam int PAT_W  = 64;
    localparam int LEN_W  = 4;

    localparam logic [BYTE_W-1:0] STAR_BYTE = 8'h2A;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_PATTERN_BYTES  = 1'b0,
        CFG_PATTERN_LENGTH = 1'b1
    } cfg_index_t;

    // per-cell control from the window controller
    typedef struct packed {
        logic shift;     // window moves one place toward the head
        logic append;    // a data item is written this cycle
        logic take_new;  // this cell is the next free slot
    } cell_ctrl_t;

endpackage

### rtl/spc_cell.sv
// one window cell: holds a byte, compares it with its pattern byte
module spc_cell
    import spc_pkg::*;
(
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic [BYTE_W-1:0] new_byte,
    input  logic [BYTE_W-1:0] nbr_byte,
    input  logic [BYTE_W-1:0] pat_byte,
    output logic [BYTE_W-1:0] eff_byte,
    output logic              match
);

    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;

    // the byte this slot holds once the incoming item is counted in
    assign eff_byte = ctrl.take_new ? new_byte : byte_reg;
    assign match    = (eff_byte == pat_byte);

    // shift takes the neighbor's view, otherwise the free slot takes the new byte
    always_comb
    begin
        byte_next = byte_reg;
        if (ctrl.shift)
        begin
            byte_next = nbr_byte;
        end
        else if (ctrl.append && ctrl.take_new)
        begin
            byte_next = new_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

endmodule

### rtl/stream_pattern_censor.sv
// top level of the stream pattern censor: cell chain, run control, output register
//
// Replaces each greedy, non-overlapping occurrence of the programmed pattern in a byte
// stream with a run of asterisks of the same length; an end-of-stream item flushes
// the undecided bytes unchanged. The window is a row of PATTERN_MAX cells, each
// comparing its byte with one pattern byte; every emitted result shifts the row by one.
// An item that causes at most one result is taken every cycle while the output is not
// stalled and no run is draining. A match blocks input while the rest of its asterisk
// run drains, and an end-of-stream item with bytes held blocks input while the rest
// of the flush drains, so text without matches sustains one item per cycle. Results
// come from a single output register; input stall follows output stall in the same
// cycle. Configuration is written through cfg_valid/cfg_ready, always ready, and must
// only change while the block is idle.
module stream_pattern_censor
    import spc_pkg::*;
#(
    parameter int PATTERN_MAX = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration writes
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [0:0]        cfg_index,
    input  logic [PAT_W-1:0]  cfg_data,
    // input items
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              end_of_stream,
    // result items
    output logic              out_valid,
    input  logic              out_stall,
    output logic [BYTE_W-1:0] out_byte,
    output logic              last_of_run
);

    localparam int CW = $clog2(PATTERN_MAX + 1);

    // configuration registers
    logic [PAT_W-1:0] pattern_bytes_reg;
    logic [LEN_W-1:0] pattern_length_reg;

    // control state
    logic [CW-1:0]     held_reg, held_next;
    logic [CW-1:0]     run_left_reg, run_left_next;
    logic              run_star_reg, run_star_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;

    // cell chain
    cell_ctrl_t        cell_ctrl [PATTERN_MAX];
    logic [BYTE_W-1:0] eff_byte [PATTERN_MAX+1];
    logic [PATTERN_MAX-1:0] match_vec;
    logic [PATTERN_MAX-1:0] len_mask;

    logic [CW-1:0]     len_eff;
    logic [CW-1:0]     held_plus;
    logic              adv;
    logic              run_active;
    logic              accept;
    logic              hit;
    logic              shift;
    logic              append;
    logic              emit;
    logic [BYTE_W-1:0] emit_byte;
    logic              emit_last;

    assign cfg_ready = 1'b1;

    // configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg  <= '0;
            pattern_length_reg <= LEN_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PATTERN_BYTES:  pattern_bytes_reg  <= cfg_data;
                CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[LEN_W-1:0];
                default:            pattern_bytes_reg  <= pattern_bytes_reg;
            endcase
        end
    end

    // effective pattern length, clamped to 1..PATTERN_MAX
    always_comb
    begin
        priority if (pattern_length_reg == '0)
        begin
            len_eff = CW'(1);
        end
        else if (pattern_length_reg > LEN_W'(PATTERN_MAX))
        begin
            len_eff = CW'(PATTERN_MAX);
        end
        else
        begin
            len_eff = pattern_length_reg[CW-1:0];
        end
    end

    // handshake
    assign adv        = !out_valid_reg || !out_stall;
    assign run_active = (run_left_reg != '0);
    assign in_stall   = run_active || !adv;
    assign accept     = in_valid && !in_stall;
    assign held_plus  = held_reg + CW'(1);

    // cells past the last one see the incoming byte
    assign eff_byte[PATTERN_MAX] = data_byte;

    genvar gi;
    generate
        for (gi = 0; gi < PATTERN_MAX; gi++)
        begin : g_cell
            assign cell_ctrl[gi].shift    = shift;
            assign cell_ctrl[gi].append   = append;
            assign cell_ctrl[gi].take_new = (held_reg == CW'(gi));
            assign len_mask[gi]           = (CW'(gi) < len_eff);

            spc_cell u_cell (
                .clk      (clk),
                .ctrl     (cell_ctrl[gi]),
                .new_byte (data_byte),
                .nbr_byte (eff_byte[gi+1]),
                .pat_byte (pattern_bytes_reg[BYTE_W*gi +: BYTE_W]),
                .eff_byte (eff_byte[gi]),
                .match    (match_vec[gi])
            );
        end
    endgenerate

    // every cell inside the pattern length must agree
    assign hit = &(match_vec | ~len_mask);

    // run control and decision
    always_comb
    begin
        shift         = 1'b0;
        append        = 1'b0;
        emit          = 1'b0;
        emit_byte     = eff_byte[0];
        emit_last     = 1'b0;
        held_next     = held_reg;
        run_left_next = run_left_reg;
        run_star_next = run_star_reg;

        priority if (run_active)
        begin
            // drain an asterisk run or a flush, one result a cycle while the output advances
            if (adv)
            begin
                emit          = 1'b1;
                shift         = 1'b1;
                emit_byte     = run_star_reg ? STAR_BYTE : eff_byte[0];
                emit_last     = (run_left_reg == CW'(1));
                held_next     = held_reg - CW'(1);
                run_left_next = run_left_reg - CW'(1);
            end
        end
        else if (accept && end_of_stream)
        begin
            // flush held bytes unchanged
            if (held_reg != '0)
            begin
                emit          = 1'b1;
                shift         = 1'b1;
                emit_byte     = eff_byte[0];
                emit_last     = (held_reg == CW'(1));
                held_next     = held_reg - CW'(1);
                run_left_next = held_reg - CW'(1);
                run_star_next = 1'b0;
            end
        end
        else if (accept)
        begin
            append = 1'b1;
            if (held_plus >= len_eff)
            begin
                emit      = 1'b1;
                shift     = 1'b1;
                held_next = held_reg;
                if (hit)
                begin
                    emit_byte     = STAR_BYTE;
                    emit_last     = (len_eff == CW'(1));
                    run_left_next = len_eff - CW'(1);
                    run_star_next = 1'b1;
                end
                else
                begin
                    emit_byte = eff_byte[0];
                    emit_last = 1'b1;
                end
            end
            else
            begin
                held_next = held_plus;
            end
        end
        else
        begin
            // idle: everything holds
            held_next = held_reg;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (adv)
        begin
            out_valid_next = emit;
            if (emit)
            begin
                out_byte_next = emit_byte;
                out_last_next = emit_last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            run_left_reg  <= '0;
            run_star_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            held_reg      <= held_next;
            run_left_reg  <= run_left_next;
            run_star_reg  <= run_star_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = out_last_reg;

endmodule
